### src/two_wire_display_link_serializer_unit_macros.svh
// assertion macros used by the serializer controller
`ifndef TWO_WIRE_DISPLAY_LINK_SERIALIZER_UNIT_MACROS_SVH
`define TWO_WIRE_DISPLAY_LINK_SERIALIZER_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define TWDLS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define TWDLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/twdls_pkg.sv
package twdls_pkg;

    // bits shifted out per byte
    localparam int BITS_PER_BYTE = 8;

    localparam int STEP_W = 5;
    localparam int TICK_W = 16;

    // phase step codes within one byte
    localparam logic [STEP_W-1:0] STEP_START     = 5'd0;
    localparam logic [STEP_W-1:0] STEP_FIRST_BIT = 5'd1;
    localparam logic [STEP_W-1:0] STEP_ACK_LO    = 5'(2 * BITS_PER_BYTE + 1);
    localparam logic [STEP_W-1:0] STEP_ACK_HI    = 5'(2 * BITS_PER_BYTE + 2);
    localparam logic [STEP_W-1:0] STEP_STOP_LO   = 5'(2 * BITS_PER_BYTE + 3);
    localparam logic [STEP_W-1:0] STEP_STOP_HI   = 5'(2 * BITS_PER_BYTE + 4);
    localparam logic [STEP_W-1:0] STEP_STOP_RISE = 5'(2 * BITS_PER_BYTE + 5);

    // reset hold time per phase
    localparam logic [TICK_W-1:0] PHASE_TICKS_RESET = 16'd5;

    // commands from controller to datapath
    typedef struct packed {
        logic start_item;
        logic advance;
        logic tick_clr;
        logic tick_inc;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic last_phase;
        logic hold_done;
    } t_dp_sts;

endpackage

### src/twdls_dp.sv
module twdls_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  twdls_pkg::t_dp_cmd         i_cmd,
    output twdls_pkg::t_dp_sts         o_sts,
    input  logic                       i_cfg_we,
    input  logic [twdls_pkg::TICK_W-1:0] i_cfg_phase_ticks,
    input  logic [7:0]                 i_byte_value,
    input  logic                       i_frame_start,
    input  logic                       i_frame_end,
    output logic                       o_clock_level,
    output logic                       o_data_level,
    output logic                       o_data_drive,
    output logic                       o_last_phase
);

    logic [twdls_pkg::TICK_W-1:0] r_phase_ticks;
    logic [twdls_pkg::TICK_W-1:0] r_tick;
    logic [twdls_pkg::TICK_W-1:0] n_tick;
    logic [twdls_pkg::STEP_W-1:0] r_step;
    logic [twdls_pkg::STEP_W-1:0] n_step;
    logic                         r_in_frame;
    logic                         n_in_frame;
    logic [7:0]                   r_byte;
    logic                         r_stop;
    logic [twdls_pkg::STEP_W-1:0] bit_pos;
    logic [twdls_pkg::TICK_W:0]   tick_plus;
    logic                         start_now;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= twdls_pkg::PHASE_TICKS_RESET;
        end else if (i_cfg_we) begin
            r_phase_ticks <= i_cfg_phase_ticks;
        end
    end

    // start only when no frame is open
    assign start_now = i_frame_start && !r_in_frame;

    // step and frame next state
    always_comb begin
        n_step     = r_step;
        n_in_frame = r_in_frame;
        if (i_cmd.start_item) begin
            n_step     = start_now ? twdls_pkg::STEP_START : twdls_pkg::STEP_FIRST_BIT;
            n_in_frame = i_frame_end ? 1'b0 : (r_in_frame | i_frame_start);
        end else if (i_cmd.advance) begin
            n_step = r_step + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= twdls_pkg::STEP_START;
            r_in_frame <= 1'b0;
        end else begin
            r_step     <= n_step;
            r_in_frame <= n_in_frame;
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_item) begin
            r_byte <= i_byte_value;
            r_stop <= i_frame_end;
        end
    end

    // hold counter, zero ticks behaves as one
    always_comb begin
        n_tick = r_tick;
        if (i_cmd.tick_clr) begin
            n_tick = '0;
        end else if (i_cmd.tick_inc) begin
            n_tick = r_tick + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
        end else begin
            r_tick <= n_tick;
        end
    end

    assign tick_plus       = {1'b0, r_tick} + 17'd1;
    assign o_sts.hold_done = (tick_plus >= {1'b0, r_phase_ticks});

    // pin levels for the current phase
    assign bit_pos = r_step - twdls_pkg::STEP_FIRST_BIT;

    always_comb begin
        if (r_step == twdls_pkg::STEP_START) begin
            o_clock_level = 1'b1;
            o_data_level  = 1'b0;
            o_data_drive  = 1'b1;
        end else if (r_step < twdls_pkg::STEP_ACK_LO) begin
            o_clock_level = ~r_step[0];
            o_data_level  = r_byte[bit_pos[3:1]];
            o_data_drive  = 1'b1;
        end else if (r_step == twdls_pkg::STEP_ACK_LO) begin
            o_clock_level = 1'b0;
            o_data_level  = 1'b1;
            o_data_drive  = 1'b0;
        end else if (r_step == twdls_pkg::STEP_ACK_HI) begin
            o_clock_level = 1'b1;
            o_data_level  = 1'b1;
            o_data_drive  = 1'b0;
        end else if (r_step == twdls_pkg::STEP_STOP_LO) begin
            o_clock_level = 1'b0;
            o_data_level  = 1'b0;
            o_data_drive  = 1'b1;
        end else if (r_step == twdls_pkg::STEP_STOP_HI) begin
            o_clock_level = 1'b1;
            o_data_level  = 1'b0;
            o_data_drive  = 1'b1;
        end else begin
            o_clock_level = 1'b1;
            o_data_level  = 1'b1;
            o_data_drive  = 1'b1;
        end
    end

    // final phase of the byte
    assign o_last_phase     = ((r_step == twdls_pkg::STEP_ACK_HI) && !r_stop)
                              || (r_step == twdls_pkg::STEP_STOP_RISE);
    assign o_sts.last_phase = o_last_phase;

endmodule

### src/twdls_ctrl.sv
`include "two_wire_display_link_serializer_unit_macros.svh"

module twdls_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    output logic               o_valid,
    input  logic               i_stall,
    input  twdls_pkg::t_dp_sts i_sts,
    output twdls_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SEND = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // handshake outputs
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_SEND);

    // sequencing of phases
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.start_item = 1'b1;
                    n_state          = S_SEND;
                end
            end
            S_SEND: begin
                if (!i_stall) begin
                    o_cmd.tick_clr = 1'b1;
                    n_state        = S_HOLD;
                end
            end
            S_HOLD: begin
                o_cmd.tick_inc = 1'b1;
                if (i_sts.hold_done) begin
                    if (i_sts.last_phase) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state       = S_SEND;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // a request taken on the input shows a phase next cycle
    `TWDLS_ASSERT_NEXT(a_accept_to_send, i_clk, i_rst_n, i_valid && !o_stall, o_valid,
        "accepted request did not start a phase")
    // no request is taken while a phase is offered
    `TWDLS_ASSERT_NOW(a_busy_while_send, i_clk, i_rst_n, o_valid, o_stall,
        "input open while a phase is offered")
    // hold lasts until the counter expires
    `TWDLS_ASSERT_NEXT(a_hold_waits, i_clk, i_rst_n,
        (r_state == S_HOLD) && !i_sts.hold_done, r_state == S_HOLD,
        "hold left before the tick count expired")

endmodule

### src/two_wire_display_link_serializer_unit.sv
// Two-wire display link serializer, bit-level master, LSB first.
// Input channel (i_valid / o_stall) takes one byte request with flags for a
// start condition before it and a stop condition after it. The start is
// skipped when a frame is already open.
// Output channel (o_valid / i_stall) gives one pin phase per request:
// clock level, data level, data drive enable and a last-phase marker.
// A byte gives 18 phases, plus 1 for a start and 3 for a stop (up to 22).
// Config channel (i_cfg_valid / o_cfg_ready, ready always high) writes
// phase_ticks, the hold time of each phase; 0 behaves as 1.
// The first phase is offered in the cycle after the byte is taken. Each
// phase is handed over in the send state and then kept for its hold time,
// counted by the hold counter in the datapath; after the last hold ends
// the block goes back to idle, where it takes the next byte. One byte is
// in work at a time. While the receiver stalls, the offered phase holds
// and the hold count does not start. Reset empties the block, closes any
// frame and sets phase_ticks to 5.
module two_wire_display_link_serializer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte_value,
    input  logic        i_frame_start,
    input  logic        i_frame_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_clock_level,
    output logic        o_data_level,
    output logic        o_data_drive,
    output logic        o_last_phase,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_phase_ticks
);

    twdls_pkg::t_dp_cmd cmd;
    twdls_pkg::t_dp_sts sts;

    // config always accepted
    assign o_cfg_ready = 1'b1;

    // controller
    twdls_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // datapath
    twdls_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_phase_ticks (i_cfg_phase_ticks),
        .i_byte_value      (i_byte_value),
        .i_frame_start     (i_frame_start),
        .i_frame_end       (i_frame_end),
        .o_clock_level     (o_clock_level),
        .o_data_level      (o_data_level),
        .o_data_drive      (o_data_drive),
        .o_last_phase      (o_last_phase)
    );

endmodule
